// File: rtl/cme_pkg.sv
// Shared types, symbol codes and the letter code table of the Cyrillic Morse encoder.
package cme_pkg;

   localparam int unsigned MaxSyms = 8;
   localparam int unsigned SymW = 2;
   localparam int unsigned CountW = 4;

   typedef logic [SymW-1:0] sym_type;

   localparam sym_type SYM_DOT  = 2'd0;
   localparam sym_type SYM_DASH = 2'd1;
   localparam sym_type SYM_GAP  = 2'd2;
   localparam sym_type SYM_END  = 2'd3;

   typedef struct packed {
      logic load;
      logic advance;
   } ctl_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_one;
   } dp_status_type;

   typedef struct packed {
      logic [2:0] len;
      logic [5:0] pat;
   } code_type;

   // pat holds the first symbol in bit 5; a 1 is a dash
   function automatic code_type letter_code(input logic [4:0] idx);
      code_type c;
      case (idx)
         5'd0:  c = '{3'd2, 6'b010000};
         5'd1:  c = '{3'd4, 6'b100000};
         5'd2:  c = '{3'd3, 6'b011000};
         5'd3:  c = '{3'd3, 6'b110000};
         5'd4:  c = '{3'd3, 6'b100000};
         5'd5:  c = '{3'd1, 6'b000000};
         5'd6:  c = '{3'd4, 6'b000100};
         5'd7:  c = '{3'd4, 6'b110000};
         5'd8:  c = '{3'd2, 6'b000000};
         5'd9:  c = '{3'd4, 6'b011100};
         5'd10: c = '{3'd3, 6'b101000};
         5'd11: c = '{3'd4, 6'b010000};
         5'd12: c = '{3'd2, 6'b110000};
         5'd13: c = '{3'd2, 6'b100000};
         5'd14: c = '{3'd3, 6'b111000};
         5'd15: c = '{3'd4, 6'b011000};
         5'd16: c = '{3'd3, 6'b010000};
         5'd17: c = '{3'd3, 6'b000000};
         5'd18: c = '{3'd1, 6'b100000};
         5'd19: c = '{3'd3, 6'b001000};
         5'd20: c = '{3'd4, 6'b001000};
         5'd21: c = '{3'd4, 6'b000000};
         5'd22: c = '{3'd4, 6'b101000};
         5'd23: c = '{3'd4, 6'b111000};
         5'd24: c = '{3'd4, 6'b111100};
         5'd25: c = '{3'd4, 6'b110100};
         5'd26: c = '{3'd6, 6'b011010};
         5'd27: c = '{3'd4, 6'b101100};
         5'd28: c = '{3'd4, 6'b100100};
         5'd29: c = '{3'd5, 6'b001000};
         5'd30: c = '{3'd4, 6'b001100};
         5'd31: c = '{3'd4, 6'b010100};
         default: c = '{3'd0, 6'b000000};
      endcase
      return c;
   endfunction

endpackage

// File: rtl/cme_datapath.sv
// Datapath: text state, symbol list build and symbol shift queue.
module cme_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  cme_pkg::ctl_cmd_type   cmd,
   input  logic [7:0]             req_text_byte,
   input  logic                   req_end_of_text,
   output cme_pkg::dp_status_type status,
   output cme_pkg::sym_type       rsp_symbol,
   output logic                   rsp_bad_char_seen,
   output logic                   rsp_run_last
);
   import cme_pkg::*;

   localparam int unsigned ListW = MaxSyms * SymW;

   logic                after_space_ff, after_space_in;
   logic                held_gap_ff, held_gap_in;
   logic                bad_flag_ff, bad_flag_in;
   logic                bad_end_ff, bad_end_in;
   logic [CountW-1:0]   count_ff, count_in;
   logic [ListW-1:0]    list_ff, list_in;

   logic                is_space, space_first, is_letter, is_other, pre;
   code_type            code;
   logic [11:0]         body;
   logic [2:0]          body_len;
   logic [ListW-1:0]    built;
   logic [CountW-1:0]   built_len;

   assign is_space    = (req_text_byte == 8'd32);
   assign space_first = is_space & ~after_space_ff;
   assign is_letter   = (req_text_byte[7:6] == 2'b11);
   assign is_other    = ~is_space & ~is_letter;
   assign pre         = held_gap_ff & (space_first | is_letter);
   assign code        = letter_code(req_text_byte[4:0]);

   always_comb begin
      body     = '0;
      body_len = 3'd0;
      if (space_first) begin
         body     = {8'd0, SYM_GAP, SYM_GAP};
         body_len = 3'd2;
      end else if (is_letter) begin
         for (int i = 0; i < 6; i++) begin
            body[2*i +: 2] = code.pat[5-i] ? SYM_DASH : SYM_DOT;
         end
         body_len = code.len;
      end
   end

   always_comb begin
      built     = {4'd0, body} << (pre ? 2 : 0);
      built_len = CountW'(body_len) + CountW'(pre);
      if (pre) begin
         built[1:0] = SYM_GAP;
      end
      if (req_end_of_text) begin
         built[2*built_len[2:0] +: 2] = SYM_END;
         built_len                    = built_len + CountW'(1);
      end
   end

   always_comb begin
      after_space_in = after_space_ff;
      held_gap_in    = held_gap_ff;
      bad_flag_in    = bad_flag_ff;
      bad_end_in     = bad_end_ff;
      count_in       = count_ff;
      list_in        = list_ff;
      if (cmd.load) begin
         list_in    = built;
         count_in   = built_len;
         bad_end_in = bad_flag_ff | is_other;
         if (req_end_of_text) begin
            after_space_in = 1'b0;
            held_gap_in    = 1'b0;
            bad_flag_in    = 1'b0;
         end else begin
            after_space_in = is_space;
            held_gap_in    = held_gap_ff | space_first | is_letter;
            bad_flag_in    = bad_flag_ff | is_other;
         end
      end else if (cmd.advance) begin
         list_in  = list_ff >> SymW;
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         after_space_ff <= 1'b0;
         held_gap_ff    <= 1'b0;
         bad_flag_ff    <= 1'b0;
         count_ff       <= '0;
      end else begin
         after_space_ff <= after_space_in;
         held_gap_ff    <= held_gap_in;
         bad_flag_ff    <= bad_flag_in;
         count_ff       <= count_in;
      end
      list_ff    <= list_in;
      bad_end_ff <= bad_end_in;
   end

   assign status.count_zero = (count_ff == CountW'(0));
   assign status.count_one  = (count_ff == CountW'(1));
   assign rsp_symbol        = list_ff[SymW-1:0];
   assign rsp_bad_char_seen = (list_ff[SymW-1:0] == SYM_END) & bad_end_ff;
   assign rsp_run_last      = status.count_one;
endmodule

// File: rtl/cme_controller.sv
// Controller: accepts one request, then sequences its symbols out.
module cme_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  cme_pkg::dp_status_type status,
   output cme_pkg::ctl_cmd_type   cmd
);
   import cme_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   state_type state_ff;
   logic      stall_ff;

   assign req_stall   = stall_ff;
   assign rsp_valid   = (state_ff == ST_EMIT) & ~status.count_zero;
   assign cmd.load    = (state_ff == ST_IDLE) & req_valid & ~stall_ff;
   assign cmd.advance = rsp_valid & ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (cmd.load) begin
                  state_ff <= ST_EMIT;
                  stall_ff <= 1'b1;
               end
            end
            ST_EMIT: begin
               if (status.count_zero || (cmd.advance && status.count_one)) begin
                  state_ff <= ST_IDLE;
                  stall_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               stall_ff <= 1'b0;
            end
         endcase
      end
   end
endmodule

// File: rtl/cyrillic_morse_encoder.sv
// Top level of the Cyrillic Morse encoder: controller plus datapath.
//
// Request channel (req_): one Windows-1251 byte per request with an
// end-of-text mark; accepted when req_valid is high and req_stall low.
// Response channel (rsp_): one Morse symbol per response (dot, dash, gap,
// end), accepted when rsp_valid is high and rsp_stall low. rsp_run_last
// marks the final symbol caused by a request; rsp_bad_char_seen is set on
// the end symbol when a byte without a code appeared in the text.
// The first symbol of a request is valid in the cycle after accept.
// A request occupies the block until its last symbol is taken, since the
// symbol queue drains one symbol per cycle while rsp_stall is low; a
// request produces up to 8 symbols.
// req_stall stays high from accept until the last symbol is taken.
// Reset clears the space, held-gap and pending bad-character state and empties the queue by clearing its count.
// A stalled receiver holds the current symbol; nothing is lost or dropped.
module cyrillic_morse_encoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_text_byte,
   input  logic             req_end_of_text,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cme_pkg::sym_type rsp_symbol,
   output logic             rsp_bad_char_seen,
   output logic             rsp_run_last
);
   import cme_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   cme_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cme_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_text_byte     (req_text_byte),
      .req_end_of_text   (req_end_of_text),
      .status            (status),
      .rsp_symbol        (rsp_symbol),
      .rsp_bad_char_seen (rsp_bad_char_seen),
      .rsp_run_last      (rsp_run_last)
   );

   a_busy_while_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while symbols pending");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_symbol == SYM_END) |-> rsp_run_last)
      else $error("end symbol not last of its request");

   a_bad_only_on_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_char_seen) |-> (rsp_symbol == SYM_END))
      else $error("bad flag on non-end symbol");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_run_last) |=> (!rsp_valid && !req_stall))
      else $error("block not idle after last symbol");
endmodule

// File: tb/cyrillic_morse_encoder_test.sv
// Self-checking testbench for the Cyrillic Morse encoder with a predicting scoreboard.
`timescale 1ns / 1ps

module cyrillic_morse_encoder_test;
   import cme_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      sym_type symbol;
      logic    bad_char;
      logic    run_last;
   } morse_symbol_type;

   class morse_scoreboard;
      morse_symbol_type symbol_q[$];
      string            letter_codes[32];
      bit               after_space;
      bit               held_gap;
      bit               bad_flag;
      int               error_count;

      function new();
         letter_codes = '{
            ".-",   "-...", ".--",  "--.",  "-..",  ".",      "...-", "--..",
            "..",   ".---", "-.-",  ".-..", "--",   "-.",     "---",  ".--.",
            ".-.",  "...",  "-",    "..-",  "..-.", "....",   "-.-.", "---.",
            "----", "--.-", ".--.-.", "-.--", "-..-", "..-..", "..--", ".-.-"
         };
         after_space = 0;
         held_gap = 0;
         bad_flag = 0;
         error_count = 0;
      endfunction

      function int pending();
         return symbol_q.size();
      endfunction

      function void note_request(logic [7:0] text_byte, logic end_of_text);
         sym_type          syms[$];
         logic             bads[$];
         logic [7:0]       upper;
         string            code;
         morse_symbol_type item;
         if (text_byte == 8'd32) begin
            if (!after_space) begin
               if (held_gap) begin
                  syms.push_back(SYM_GAP);
                  bads.push_back(1'b0);
               end
               repeat (2) begin
                  syms.push_back(SYM_GAP);
                  bads.push_back(1'b0);
               end
               held_gap = 1;
               after_space = 1;
            end
         end else begin
            upper = (text_byte >= 8'd224) ? text_byte - 8'd32 : text_byte;
            after_space = 0;
            if (upper >= 8'd192) begin
               code = letter_codes[upper - 8'd192];
               if (held_gap) begin
                  syms.push_back(SYM_GAP);
                  bads.push_back(1'b0);
               end
               for (int i = 0; i < code.len(); i++) begin
                  syms.push_back(code[i] == "-" ? SYM_DASH : SYM_DOT);
                  bads.push_back(1'b0);
               end
               held_gap = 1;
            end else begin
               bad_flag = 1;
            end
         end
         if (end_of_text) begin
            syms.push_back(SYM_END);
            bads.push_back(bad_flag);
            after_space = 0;
            held_gap = 0;
            bad_flag = 0;
         end
         for (int i = 0; i < syms.size(); i++) begin
            item.symbol = syms[i];
            item.bad_char = bads[i];
            item.run_last = (i == syms.size() - 1);
            symbol_q.push_back(item);
         end
      endfunction

      function void check_response(sym_type symbol, logic bad_char, logic run_last);
         morse_symbol_type want;
         if (symbol_q.size() == 0) begin
            $error("unexpected response: symbol %0d", symbol);
            error_count++;
            return;
         end
         want = symbol_q.pop_front();
         if (symbol !== want.symbol) begin
            $error("symbol: expected %0d, actual %0d", want.symbol, symbol);
            error_count++;
         end
         if (bad_char !== want.bad_char) begin
            $error("bad_char_seen: expected %0d, actual %0d", want.bad_char, bad_char);
            error_count++;
         end
         if (run_last !== want.run_last) begin
            $error("run_last: expected %0d, actual %0d", want.run_last, run_last);
            error_count++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_text_byte = 8'd0;
   logic       req_end_of_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   sym_type    rsp_symbol;
   logic       rsp_bad_char_seen;
   logic       rsp_run_last;

   morse_scoreboard sb;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int items_sent = 0;
   int cycle_count = 0;

   cyrillic_morse_encoder uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_text_byte(req_text_byte),
      .req_end_of_text(req_end_of_text),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_symbol(rsp_symbol),
      .rsp_bad_char_seen(rsp_bad_char_seen),
      .rsp_run_last(rsp_run_last)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_served < hold_requests) begin
         rsp_stall <= 1'b1;
         hold_served++;
         hold_left = HOLD_CYCLES - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_response(rsp_symbol, rsp_bad_char_seen, rsp_run_last);
      end
   end

   task automatic send_request(input logic [7:0] text_byte, input logic end_of_text);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= text_byte;
      req_end_of_text <= end_of_text;
      do @(posedge clock); while (req_stall);
      sb.note_request(text_byte, end_of_text);
      items_sent++;
   endtask

   function automatic logic [7:0] random_bad_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(191)); while (b == 8'd32);
      return b;
   endfunction

   task automatic send_text(input int word_max);
      int words;
      int len;
      int ending;
      logic [7:0] b;
      logic eot;
      words = $urandom_range(word_max, 1);
      ending = $urandom_range(99);
      if ($urandom_range(9) == 0) send_request(8'd32, 1'b0);
      for (int i = 0; i < words; i++) begin
         len = $urandom_range(6, 1);
         for (int j = 0; j < len; j++) begin
            b = ($urandom_range(99) < 8) ? random_bad_byte() : 8'($urandom_range(255, 192));
            eot = (ending < 70) && (i == words - 1) && (j == len - 1);
            send_request(b, eot);
         end
         if (i < words - 1) begin
            repeat ($urandom_range(3, 1)) send_request(8'd32, 1'b0);
         end
      end
      if (ending >= 85) send_request(8'd32, 1'b1);
      else if (ending >= 70) send_request(random_bad_byte(), 1'b1);
   endtask

   initial begin
      int target;
      sb = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_request(8'd192, 1'b0);
      send_request(8'd255, 1'b0);
      send_request(8'd224, 1'b0);
      send_request(8'd223, 1'b0);
      send_request(8'd218, 1'b0);
      send_request(8'd32, 1'b0);
      send_request(8'd32, 1'b0);
      send_request(8'd0, 1'b0);
      send_request(8'd193, 1'b0);
      send_request(8'd191, 1'b0);
      send_request(8'd32, 1'b1);
      send_request(8'd194, 1'b1);
      send_request(8'd127, 1'b1);
      send_request(8'd32, 1'b0);
      send_request(8'd0, 1'b0);
      send_request(8'd32, 1'b0);
      send_request(8'd200, 1'b1);
      send_request(8'd221, 1'b0);
      send_request(8'd222, 1'b0);
      send_request(8'd7, 1'b1);
      send_request(8'd255, 1'b1);

      target = items_sent;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
         endcase
         target += 20;
         while (items_sent < target) begin
            if ($urandom_range(99) < 85) begin
               send_text(4);
            end else begin
               send_request(8'($urandom), $urandom_range(9) == 0);
            end
         end
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_requests++;
      send_text(6);
      send_text(6);

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
